/* hw/rtl/motion_light_mode_timer_unit_assert.svh */
// Assertion macros shared by the motion light timer RTL.
`ifndef MOTION_LIGHT_MODE_TIMER_UNIT_ASSERT_SVH
`define MOTION_LIGHT_MODE_TIMER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define MLMT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("motion light timer check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define MLMT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("motion light timer check failed");

`endif

/* hw/rtl/mlmt_pkg.sv */
// Types, constants and helpers shared by the motion light timer modules.
`timescale 1ns / 1ps

package mlmt_pkg;

	localparam int unsigned DUR_W     = 16;
	localparam int unsigned ELAPSED_W = 26;
	localparam int unsigned SINCE_W   = 6;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned CMD_W     = 2;
	localparam int unsigned CFG_IDX_W = 2;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INC  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DEC  = 2'd2;

	// Mode codes. Code 3 can be loaded and simply freezes the lamp.
	localparam logic [MODE_W-1:0] MODE_MOTION     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FORCED_ON  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FORCED_OFF = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_INIT_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_HOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_ON   = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [MODE_W-1:0] RST_MODE = MODE_MOTION;
	localparam logic [DUR_W-1:0]  RST_HOLD = 16'd30;
	localparam logic [DUR_W-1:0]  RST_ON   = 16'd600;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 26'h3FF_FFFF;
	localparam logic [SINCE_W-1:0]   SINCE_MAX   = 6'h3F;
	localparam logic [SINCE_W-1:0]   CHECK_GAP   = 6'd50;
	localparam logic [ELAPSED_W-1:0] MS_PER_S    = 26'd1000;

	localparam logic [DUR_W-1:0]     HOLD_STEP    = 16'd5;
	localparam logic [DUR_W-1:0]     ON_STEP      = 16'd10;
	localparam logic [DUR_W-1:0]     DUR_MAX      = 16'hFFFF;
	localparam logic [ELAPSED_W-1:0] HOLD_STEP_MS = 26'd5000;
	localparam logic [ELAPSED_W-1:0] ON_STEP_MS   = 26'd10000;
	localparam logic [ELAPSED_W-1:0] DUR_MAX_MS   = 26'd65535000;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             motion;
	} cmd_word_t;

	typedef struct packed {
		logic              light_on;
		logic [MODE_W-1:0] mode_now;
		logic              state_changed;
		logic [DUR_W-1:0]  hold_seconds_now;
		logic [DUR_W-1:0]  on_seconds_now;
	} res_word_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [DUR_W-1:0]     wdata;
	} cfg_wr_t;

	// Seconds to milliseconds; the largest product still fits in 26 bits.
	function automatic logic [ELAPSED_W-1:0] ms_of(input logic [DUR_W-1:0] secs);
		logic [ELAPSED_W-1:0] prod;
		prod = ELAPSED_W'(secs) * MS_PER_S;
		return prod;
	endfunction

endpackage

/* hw/rtl/motion_light_mode_timer_unit.sv */
// Top level of the motion-activated light timer with its result register.
`timescale 1ns / 1ps

//  channel | signals                                  | direction | role
//  --------+------------------------------------------+-----------+---------------------------
//  cmd     | cmd_valid, cmd_ready, cmd_word           | in        | tick, increase, decrease
//  res     | res_valid, res_ready, res_word           | out       | one result word per command
//  cfg     | cfg_we, cfg_index, cfg_wdata             | in        | register writes, no wait
//
// Each command word is held in the input register and is then folded
// into the timer state in one pass, its result landing in the result register;
// while results are taken, a word can be accepted every cycle. After reset the
// block is empty and ready, with the lamp dark and the mode, hold and on
// durations at their register reset values.
// A stalled result holds the result register; the input register then fills
// and cmd_ready drops until the result is taken.

module motion_light_mode_timer_unit
	import mlmt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  cmd_word_t            cmd_word,
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_word_t            res_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DUR_W-1:0]     cfg_wdata
);

`include "motion_light_mode_timer_unit_assert.svh"

	logic      valid_s1;
	cmd_word_t word_s1;
	logic      advance;
	res_word_t result;
	cfg_wr_t   cfg;
	logic      res_valid_s2;
	res_word_t res_word_s2;

	// The word in the input register moves on whenever the result register
	// is empty or is being emptied in this cycle. The state update happens
	// in the same cycle, so state and result register always agree.
	assign advance = valid_s1 && (!res_valid_s2 || res_ready);

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.wdata = cfg_wdata;

	mlmt_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_word (cmd_word),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	mlmt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.word  (word_s1),
		.cfg   (cfg),
		.result(result)
	);

	// Result register: loads on every advance, clears once its word is taken
	// with nothing behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_word_s2 <= result;
		end
	end

	assign res_valid = res_valid_s2;
	assign res_word  = res_word_s2;

	// A full input register behind a stalled result must hold off new words.
	`MLMT_ASSERT_NOW(a_full_blocks_input, valid_s1 && res_valid_s2 && !res_ready, !cmd_ready)
	// A word that advances always shows up as a valid result next cycle.
	`MLMT_ASSERT_NEXT(a_advance_fills_result, advance, res_valid_s2)

endmodule

/* hw/rtl/mlmt_in_reg.sv */
// Input register stage holding one accepted command word.
`timescale 1ns / 1ps

module mlmt_in_reg
	import mlmt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_word_t cmd_word,
	input  logic      advance,
	output logic      valid_s1,
	output cmd_word_t word_s1
);

	logic valid_q;

	// The stage can take a new word when it is empty or its word leaves now.
	assign cmd_ready = !valid_q || advance;
	assign valid_s1  = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd_ready) begin
			valid_q <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			word_s1 <= cmd_word;
		end
	end

endmodule

/* hw/rtl/mlmt_ctrl.sv */
// Lamp, mode, duration and counter state with its per-word update logic.
`timescale 1ns / 1ps

module mlmt_ctrl
	import mlmt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  cmd_word_t word,
	input  cfg_wr_t   cfg,
	output res_word_t result
);

`include "motion_light_mode_timer_unit_assert.svh"

	logic [MODE_W-1:0]    mode_q, mode_d;
	logic                 lamp_q, lamp_d;
	logic [DUR_W-1:0]     hold_q, hold_d;
	logic [DUR_W-1:0]     on_q, on_d;
	logic [ELAPSED_W-1:0] hold_ms_q, hold_ms_d;
	logic [ELAPSED_W-1:0] on_ms_q, on_ms_d;
	logic [ELAPSED_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [SINCE_W-1:0]   since_q, since_d, since_inc;
	logic                 changed;
	logic [DUR_W:0]       hold_sum, on_sum;

	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign since_inc   = (since_q == SINCE_MAX) ? since_q : since_q + 1'b1;
	assign hold_sum    = {1'b0, hold_q} + {1'b0, HOLD_STEP};
	assign on_sum      = {1'b0, on_q} + {1'b0, ON_STEP};

	always_comb begin
		mode_d    = mode_q;
		lamp_d    = lamp_q;
		hold_d    = hold_q;
		on_d      = on_q;
		hold_ms_d = hold_ms_q;
		on_ms_d   = on_ms_q;
		elapsed_d = elapsed_q;
		since_d   = since_q;
		changed   = 1'b0;

		if (step) begin
			case (word.command)
				CMD_TICK: begin
					elapsed_d = elapsed_inc;
					since_d   = since_inc;
					if (since_inc > CHECK_GAP) begin
						case (mode_q)
							MODE_MOTION: begin
								if ((lamp_q != word.motion) &&
								    (word.motion || (elapsed_inc >= hold_ms_q))) begin
									lamp_d    = word.motion;
									elapsed_d = '0;
									changed   = 1'b1;
								end
								since_d = '0;
							end
							MODE_FORCED_ON: begin
								if (!lamp_q) begin
									lamp_d    = 1'b1;
									elapsed_d = '0;
									changed   = 1'b1;
								end else if (elapsed_inc >= on_ms_q) begin
									mode_d = MODE_MOTION;
								end
								since_d = '0;
							end
							MODE_FORCED_OFF: begin
								if (lamp_q) begin
									lamp_d  = 1'b0;
									changed = 1'b1;
									since_d = '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				CMD_INC: begin
					if (mode_q == MODE_MOTION) begin
						hold_d    = hold_sum[DUR_W] ? DUR_MAX : hold_sum[DUR_W-1:0];
						hold_ms_d = hold_sum[DUR_W] ? DUR_MAX_MS : hold_ms_q + HOLD_STEP_MS;
					end else if (mode_q == MODE_FORCED_ON) begin
						on_d    = on_sum[DUR_W] ? DUR_MAX : on_sum[DUR_W-1:0];
						on_ms_d = on_sum[DUR_W] ? DUR_MAX_MS : on_ms_q + ON_STEP_MS;
					end
				end
				CMD_DEC: begin
					if ((mode_q == MODE_MOTION) && (hold_q > HOLD_STEP)) begin
						hold_d    = hold_q - HOLD_STEP;
						hold_ms_d = hold_ms_q - HOLD_STEP_MS;
					end else if ((mode_q == MODE_FORCED_ON) && (on_q > ON_STEP)) begin
						on_d    = on_q - ON_STEP;
						on_ms_d = on_ms_q - ON_STEP_MS;
					end
				end
				default: begin
				end
			endcase
		end

		// A register write loads the matching state at once.
		if (cfg.we) begin
			case (cfg.index)
				REG_INIT_MODE: begin
					mode_d    = cfg.wdata[MODE_W-1:0];
					elapsed_d = '0;
					since_d   = '0;
				end
				REG_INIT_HOLD: begin
					hold_d    = cfg.wdata;
					hold_ms_d = ms_of(cfg.wdata);
				end
				REG_INIT_ON: begin
					on_d    = cfg.wdata;
					on_ms_d = ms_of(cfg.wdata);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= RST_MODE;
			lamp_q    <= 1'b0;
			hold_q    <= RST_HOLD;
			on_q      <= RST_ON;
			hold_ms_q <= ms_of(RST_HOLD);
			on_ms_q   <= ms_of(RST_ON);
			elapsed_q <= '0;
			since_q   <= '0;
		end else begin
			mode_q    <= mode_d;
			lamp_q    <= lamp_d;
			hold_q    <= hold_d;
			on_q      <= on_d;
			hold_ms_q <= hold_ms_d;
			on_ms_q   <= on_ms_d;
			elapsed_q <= elapsed_d;
			since_q   <= since_d;
		end
	end

	assign result.light_on         = lamp_d;
	assign result.mode_now         = mode_d;
	assign result.state_changed    = changed;
	assign result.hold_seconds_now = hold_d;
	assign result.on_seconds_now   = on_d;

	// The millisecond thresholds must track their durations exactly.
	`MLMT_ASSERT_NOW(a_hold_ms_track, 1'b1, hold_ms_q == ms_of(hold_q))
	`MLMT_ASSERT_NOW(a_on_ms_track, 1'b1, on_ms_q == ms_of(on_q))
	// Only a tick can report a lamp change.
	`MLMT_ASSERT_NOW(a_change_on_tick, changed, step && (word.command == CMD_TICK))
	// A decision point in motion-driven or forced-on mode restarts the gap counter.
	`MLMT_ASSERT_NEXT(a_decision_clears_gap,
		step && !cfg.we && (word.command == CMD_TICK) && (since_q >= CHECK_GAP) &&
		((mode_q == MODE_MOTION) || (mode_q == MODE_FORCED_ON)),
		since_q == '0)

endmodule

/* sim/tb.sv */
// Self-checking testbench for the motion light mode timer unit.
`timescale 1ns / 1ps

// The testbench drives command words into the block, keeps its own model of the
// lamp, mode, durations and millisecond counters, and compares every result word
// with what that model predicts. Each test task covers one area of behavior. The
// tasks share send_word, which pushes one command word through the handshake, and
// the checker process, which compares each result word with the oldest prediction.
// Both sides of the block wait a random number of cycles before each word, and
// they sometimes run in bursts with no waiting at all.

module tb;
	import mlmt_pkg::*;

	localparam int unsigned MS_PER_SEC   = 1000;
	localparam int          PIPE_LATENCY = 2;
	localparam int          MAX_WAIT     = 6;

	// The command code, mode code and register index that the package leaves unnamed.
	localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
	localparam logic [MODE_W-1:0]    MODE_FROZEN = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cmd_valid;
	logic                 cmd_ready;
	cmd_word_t            cmd_word;
	logic                 res_valid;
	logic                 res_ready;
	res_word_t            res_word;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DUR_W-1:0]     cfg_wdata;

	// Our own copy of the timer state, advanced once per accepted command word.
	logic [MODE_W-1:0]    lamp_mode;
	logic                 lamp_lit;
	logic [DUR_W-1:0]     hold_s;
	logic [DUR_W-1:0]     forced_on_s;
	logic [ELAPSED_W-1:0] elapsed_ms;
	logic [SINCE_W-1:0]   since_check_ms;

	res_word_t pending_results[$];
	int        mismatch_count;
	int        send_burst;
	int        take_burst;

	motion_light_mode_timer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_word  (cmd_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Applies one command word to the timer state and returns the result word
	// the block should produce for it.
	function automatic res_word_t advance_timer(input cmd_word_t w);
		res_word_t r;
		logic      changed;
		changed = 1'b0;
		case (w.command)
			CMD_TICK: begin
				if (elapsed_ms != ELAPSED_MAX) elapsed_ms = elapsed_ms + 1'b1;
				if (since_check_ms != SINCE_MAX) since_check_ms = since_check_ms + 1'b1;
				// Decisions are only taken once more than the check gap has passed.
				if (since_check_ms > CHECK_GAP) begin
					case (lamp_mode)
						MODE_MOTION: begin
							// Motion lights the lamp at once; darkness waits out the hold time.
							if (lamp_lit != w.motion &&
								(w.motion || 32'(elapsed_ms) >= hold_s * MS_PER_SEC)) begin
								lamp_lit   = w.motion;
								elapsed_ms = '0;
								changed    = 1'b1;
							end
							since_check_ms = '0;
						end
						MODE_FORCED_ON: begin
							if (!lamp_lit) begin
								lamp_lit   = 1'b1;
								elapsed_ms = '0;
								changed    = 1'b1;
							end else if (32'(elapsed_ms) >= forced_on_s * MS_PER_SEC) begin
								lamp_mode = MODE_MOTION;
							end
							since_check_ms = '0;
						end
						MODE_FORCED_OFF: begin
							// With the lamp already dark the check counter keeps saturating.
							if (lamp_lit) begin
								lamp_lit       = 1'b0;
								changed        = 1'b1;
								since_check_ms = '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			CMD_INC: begin
				if (lamp_mode == MODE_MOTION) begin
					hold_s = (hold_s > DUR_MAX - HOLD_STEP) ? DUR_MAX : hold_s + HOLD_STEP;
				end else if (lamp_mode == MODE_FORCED_ON) begin
					forced_on_s = (forced_on_s > DUR_MAX - ON_STEP) ? DUR_MAX : forced_on_s + ON_STEP;
				end
			end
			CMD_DEC: begin
				if (lamp_mode == MODE_MOTION) begin
					if (hold_s > HOLD_STEP) hold_s = hold_s - HOLD_STEP;
				end else if (lamp_mode == MODE_FORCED_ON) begin
					if (forced_on_s > ON_STEP) forced_on_s = forced_on_s - ON_STEP;
				end
			end
			default: begin
			end
		endcase
		r.light_on         = lamp_lit;
		r.mode_now         = lamp_mode;
		r.state_changed    = changed;
		r.hold_seconds_now = hold_s;
		r.on_seconds_now   = forced_on_s;
		return r;
	endfunction

	// Number of cycles a side waits before its next word. Now and then a stretch
	// of words goes through with no waiting at all.
	function automatic int draw_gap(inout int burst_left);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// Presents one command word and holds it until the block takes it. The
	// prediction is made at the edge where the word is accepted. Valid is only
	// lowered when a gap is drawn, so back-to-back words keep it high.
	task automatic send_word(input logic [CMD_W-1:0] command, input logic motion);
		int        gap;
		cmd_word_t w;
		res_word_t predicted;
		gap      = draw_gap(send_burst);
		w.command = command;
		w.motion  = motion;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word  <= w;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		predicted       = advance_timer(w);
		pending_results = {pending_results, predicted};
	endtask

	// Register writes happen only while the block is idle, so the model takes
	// them at once.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_INIT_MODE: begin
				lamp_mode      = data[MODE_W-1:0];
				elapsed_ms     = '0;
				since_check_ms = '0;
			end
			REG_INIT_HOLD: hold_s = data;
			REG_INIT_ON:   forced_on_s = data;
			default: begin
			end
		endcase
	endtask

	// Stops sending and waits until every predicted result word has come back.
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// Random traffic. The motion level is held for runs of random length so that
	// the lamp gets to follow it at decision points. Words that are neither ticks
	// nor timer adjustments use the unused command code.
	task automatic run_traffic(input int n, input int tick_pct, input int adjust_pct,
		input int run_max);
		int   i;
		int   pick;
		int   run_left;
		logic level;
		run_left = 0;
		level    = 1'b0;
		for (i = 0; i < n; i++) begin
			if (run_left == 0) begin
				level    = 1'($urandom_range(0, 1));
				run_left = $urandom_range(1, run_max);
			end
			run_left--;
			pick = $urandom_range(0, 99);
			if (pick < tick_pct) begin
				send_word(CMD_TICK, level);
			end else if (pick < tick_pct + adjust_pct / 2) begin
				send_word(CMD_INC, 1'($urandom));
			end else if (pick < tick_pct + adjust_pct) begin
				send_word(CMD_DEC, 1'($urandom));
			end else begin
				send_word(CMD_UNUSED, 1'($urandom));
			end
		end
	endtask

	function automatic logic [DUR_W-1:0] pick_duration();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return DUR_MAX;
			2:       return DUR_W'($urandom_range(0, 12));
			default: return DUR_W'($urandom);
		endcase
	endfunction

	// Out of reset: every command code, with both motion levels.
	task automatic test_reset_values();
		send_word(CMD_UNUSED, 1'b1);
		send_word(CMD_TICK, 1'b0);
		send_word(CMD_TICK, 1'b1);
		send_word(CMD_INC, 1'b0);
		send_word(CMD_DEC, 1'b1);
		send_word(CMD_UNUSED, 1'b0);
		wait_idle();
	endtask

	// Saturation at the top, the floors at the bottom, the modes in which
	// timer commands are ignored, and a write to the unused index.
	task automatic test_duration_limits();
		write_reg(REG_INIT_HOLD, 16'd65533);
		send_word(CMD_INC, 1'b1);
		send_word(CMD_INC, 1'b0);
		wait_idle();
		write_reg(REG_INIT_HOLD, 16'd6);
		send_word(CMD_DEC, 1'b0);
		send_word(CMD_DEC, 1'b1);
		wait_idle();
		write_reg(REG_INIT_MODE, 16'(MODE_FORCED_ON));
		write_reg(REG_INIT_ON, 16'd65530);
		send_word(CMD_INC, 1'b0);
		send_word(CMD_INC, 1'b1);
		wait_idle();
		write_reg(REG_INIT_ON, 16'd11);
		send_word(CMD_DEC, 1'b1);
		send_word(CMD_DEC, 1'b0);
		wait_idle();
		write_reg(REG_INIT_MODE, 16'(MODE_FORCED_OFF));
		send_word(CMD_INC, 1'b1);
		send_word(CMD_DEC, 1'b0);
		wait_idle();
		// All ones: the mode register keeps only its low bits, giving the frozen mode.
		write_reg(REG_INIT_MODE, 16'hFFFF);
		send_word(CMD_INC, 1'b0);
		send_word(CMD_DEC, 1'b1);
		send_word(CMD_TICK, 1'b1);
		wait_idle();
		// A write to the unused index must change nothing.
		write_reg(REG_UNUSED, DUR_W'($urandom));
		send_word(CMD_UNUSED, 1'b1);
		wait_idle();
	endtask

	// Motion-driven mode with a zero hold, then with a one second hold so that
	// the lamp stays lit for a while after motion stops.
	task automatic test_motion_follow();
		write_reg(REG_INIT_MODE, 16'(MODE_MOTION));
		write_reg(REG_INIT_HOLD, 16'd0);
		run_traffic(180, 97, 0, 150);
		wait_idle();
		write_reg(REG_INIT_HOLD, 16'd1);
		run_traffic(120, 100, 0, 150);
		wait_idle();
	endtask

	// Forced on with a zero duration: the lamp lights at the first decision and
	// the block falls back to motion-driven mode at the next one.
	task automatic test_forced_on_fallback();
		int k;
		write_reg(REG_INIT_HOLD, 16'd0);
		for (k = 0; k < 4; k++) begin
			write_reg(REG_INIT_ON, 16'd0);
			write_reg(REG_INIT_MODE, 16'(MODE_FORCED_ON));
			run_traffic(55, 97, 0, 120);
			wait_idle();
		end
	endtask

	// Light the lamp in motion-driven mode first, then force it dark; after that
	// the check counter is no longer cleared at decision points.
	task automatic test_forced_off();
		int i;
		write_reg(REG_INIT_MODE, 16'(MODE_MOTION));
		write_reg(REG_INIT_HOLD, 16'd0);
		for (i = 0; i < 55; i++) send_word(CMD_TICK, 1'b1);
		wait_idle();
		write_reg(REG_INIT_MODE, {14'($urandom), MODE_FORCED_OFF});
		run_traffic(90, 97, 0, 150);
		wait_idle();
	endtask

	// Mode three keeps the lamp as it is while the counters run on.
	task automatic test_frozen_mode();
		write_reg(REG_INIT_MODE, {14'($urandom), MODE_FROZEN});
		run_traffic(50, 80, 15, 40);
		wait_idle();
	endtask

	// Random settings, extremes included, with every kind of command mixed in.
	task automatic test_mixed_settings();
		int k;
		for (k = 0; k < 6; k++) begin
			write_reg(REG_INIT_HOLD, (k == 0) ? DUR_MAX : pick_duration());
			write_reg(REG_INIT_ON, (k == 0) ? DUR_MAX : pick_duration());
			write_reg(REG_INIT_MODE, {14'($urandom), 2'($urandom_range(0, 2))});
			run_traffic(30, 70, 24, 80);
			wait_idle();
		end
	endtask

	// Result ready: waits a random number of cycles, then holds ready high until
	// one result word is taken.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = draw_gap(take_burst);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	// Every accepted result word is compared field by field with the oldest
	// prediction.
	always @(posedge clk) begin
		res_word_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with no prediction waiting");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (res_word.light_on !== want.light_on) begin
					$error("light_on: expected %0d, got %0d", want.light_on, res_word.light_on);
					mismatch_count++;
				end
				if (res_word.mode_now !== want.mode_now) begin
					$error("mode_now: expected %0d, got %0d", want.mode_now, res_word.mode_now);
					mismatch_count++;
				end
				if (res_word.state_changed !== want.state_changed) begin
					$error("state_changed: expected %0d, got %0d",
						want.state_changed, res_word.state_changed);
					mismatch_count++;
				end
				if (res_word.hold_seconds_now !== want.hold_seconds_now) begin
					$error("hold_seconds_now: expected %0d, got %0d",
						want.hold_seconds_now, res_word.hold_seconds_now);
					mismatch_count++;
				end
				if (res_word.on_seconds_now !== want.on_seconds_now) begin
					$error("on_seconds_now: expected %0d, got %0d",
						want.on_seconds_now, res_word.on_seconds_now);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n     <= 1'b0;
		cmd_valid  <= 1'b0;
		cmd_word   <= '0;
		res_ready  <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= '0;
		cfg_wdata  <= '0;
		mismatch_count = 0;
		send_burst     = 0;
		take_burst     = 0;
		lamp_mode      = RST_MODE;
		lamp_lit       = 1'b0;
		hold_s         = RST_HOLD;
		forced_on_s    = RST_ON;
		elapsed_ms     = '0;
		since_check_ms = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_duration_limits();
		test_motion_follow();
		test_forced_on_fallback();
		test_forced_off();
		test_frozen_mode();
		test_mixed_settings();

		wait_idle();
		if (mismatch_count == 0) begin
			$display("** motion_light_mode_timer_unit: PASSED **");
		end else begin
			$display("** motion_light_mode_timer_unit: FAILED **");
		end
		$finish;
	end

	// Time limit on the whole run; a correct run ends well before it.
	initial begin
		#5_000_000;
		$display("** motion_light_mode_timer_unit: FAILED **");
		$finish;
	end

endmodule
